// File: src/scc_pkg.sv
// shared payload types and command codes for the strongly connected components block
package scc_pkg;

	localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
	localparam logic [1:0] CMD_RUN      = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	localparam logic [6:0] NUM_VERTICES_RESET = 7'd64;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] src_vertex;
		logic [5:0] dst_vertex;
	} scc_in_t;

	typedef struct packed {
		logic [5:0] vertex;
		logic [6:0] component;
		logic [6:0] component_count;
		logic       last;
	} scc_out_t;

endpackage

// File: src/scc_ram.sv
// generic single write port ram with one registered read port
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/strongly_connected_components_top.sv
// top level of the strongly connected components block (kosaraju over an adjacency matrix)
//
// Command channel (cmd_valid / cmd_stall / cmd_item) takes one item per transfer:
//   add edge sets one bit of the adjacency matrix, clear empties it, run labels
//   every vertex in use and sends one result per vertex, vertex 0 first.
// Result channel (res_valid / res_stall / res_item) carries vertex, component
// number from 1, total component count and a last flag on the final vertex.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the vertex count;
// 0 acts as 1 and values above MAX_VERTICES act as MAX_VERTICES.
// Add edge reads the row, then writes back the forward and the transposed row.
// A run walks the forward graph, then the reverse graph, then sends the results;
// its steps wait on registered reads of the row, stack, finish or label memory.
// Reset clears the matrix through per-row valid flags at once and sets the vertex
// count to 64; no clearing pass is needed. While the result register is stalled
// the run waits in place; cmd_stall is high for the whole of a run or edge update.
module strongly_connected_components_top #(
	parameter int MAX_VERTICES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  scc_pkg::scc_in_t  cmd_item,
	output logic              res_valid,
	input  logic              res_stall,
	output scc_pkg::scc_out_t res_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data
);

	import scc_pkg::*;

	localparam int W  = MAX_VERTICES;
	localparam int AW = $clog2(W);
	localparam int CW = $clog2(W + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_E_WR   = 4'd1;
	localparam logic [3:0] ST_F_ROOT = 4'd2;
	localparam logic [3:0] ST_F_RD   = 4'd3;
	localparam logic [3:0] ST_F_CHK  = 4'd4;
	localparam logic [3:0] ST_F_POP  = 4'd5;
	localparam logic [3:0] ST_R_INIT = 4'd6;
	localparam logic [3:0] ST_R_K    = 4'd7;
	localparam logic [3:0] ST_R_ROOT = 4'd8;
	localparam logic [3:0] ST_R_POPV = 4'd9;
	localparam logic [3:0] ST_R_CHK  = 4'd10;
	localparam logic [3:0] ST_O_RD   = 4'd11;
	localparam logic [3:0] ST_O_LD   = 4'd12;

	// lowest set bit of a vertex mask
	function automatic logic [AW-1:0] first_set(input logic [W-1:0] m);
		logic [AW-1:0] r;
		r = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = AW'(i);
			end
		end
		return r;
	endfunction

	logic [3:0]    state_q;
	logic [6:0]    nv_cfg_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] n_eff;
	logic [W-1:0]  inuse;
	logic [W-1:0]  visited_q;
	logic [W-1:0]  pend_q;
	logic [W-1:0]  fwd_vld_q;
	logic [W-1:0]  rev_vld_q;
	logic          fwd_rv_q;
	logic          rev_rv_q;
	logic [AW-1:0] esrc_q;
	logic [AW-1:0] edst_q;
	logic [CW-1:0] root_q;
	logic [CW-1:0] sp_q;
	logic [CW-1:0] fin_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] top_q;
	logic [AW-1:0] ov_q;
	logic          res_valid_q;
	scc_out_t      res_q;

	// memory ports
	logic          fwd_we, fwd_re, rev_we, rev_re;
	logic [AW-1:0] fwd_waddr, fwd_raddr, rev_waddr, rev_raddr;
	logic [W-1:0]  fwd_wdata, fwd_rdata, rev_wdata, rev_rdata;
	logic          stk_we, stk_re, fo_we, fo_re, lbl_we, lbl_re;
	logic [AW-1:0] stk_waddr, stk_raddr, fo_waddr, fo_raddr, lbl_waddr, lbl_raddr;
	logic [AW-1:0] stk_wdata, stk_rdata, fo_wdata, fo_rdata;
	logic [CW-1:0] lbl_wdata, lbl_rdata;

	logic [W-1:0]  fwd_row, rev_row, fmask, rmask;
	logic [AW-1:0] fpick, ppick;
	logic [CW-1:0] km1, spm2;
	logic          cmd_xfer, edge_ok, out_free, out_last;

	// clamped vertex count and in-use mask
	always_comb begin
		if (nv_cfg_q == 7'd0) begin
			n_eff = CW'(1);
		end else if (nv_cfg_q > 7'(W)) begin
			n_eff = CW'(W);
		end else begin
			n_eff = CW'(nv_cfg_q);
		end
		for (int i = 0; i < W; i++) begin
			inuse[i] = i < int'(n_q);
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign edge_ok   = ({1'b0, cmd_item.src_vertex} < 7'(W)) &&
	                   ({1'b0, cmd_item.dst_vertex} < 7'(W));
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign out_last  = (CW'(ov_q) + CW'(1)) == n_q;

	// rows with a cleared valid flag read as empty
	assign fwd_row = fwd_rv_q ? fwd_rdata : '0;
	assign rev_row = rev_rv_q ? rev_rdata : '0;
	assign fmask   = fwd_row & ~visited_q & inuse;
	assign rmask   = rev_row & ~visited_q & inuse;
	assign fpick   = first_set(fmask);
	assign ppick   = first_set(pend_q);
	assign km1     = k_q - CW'(1);
	assign spm2    = sp_q - CW'(2);

	// memory control
	always_comb begin
		fwd_we = 1'b0; fwd_re = 1'b0; fwd_waddr = esrc_q; fwd_raddr = top_q;
		fwd_wdata = fwd_row | (W'(1) << edst_q);
		rev_we = 1'b0; rev_re = 1'b0; rev_waddr = edst_q; rev_raddr = ppick;
		rev_wdata = rev_row | (W'(1) << esrc_q);
		stk_we = 1'b0; stk_re = 1'b0; stk_waddr = sp_q[AW-1:0]; stk_raddr = spm2[AW-1:0];
		stk_wdata = fpick;
		fo_we = 1'b0; fo_re = 1'b0; fo_waddr = fin_q[AW-1:0]; fo_raddr = km1[AW-1:0];
		fo_wdata = top_q;
		lbl_we = 1'b0; lbl_re = 1'b0; lbl_waddr = ppick; lbl_raddr = ov_q;
		lbl_wdata = count_q;
		case (state_q)
			ST_IDLE: begin
				fwd_raddr = cmd_item.src_vertex[AW-1:0];
				rev_raddr = cmd_item.dst_vertex[AW-1:0];
				if (cmd_xfer && cmd_item.cmd == CMD_ADD_EDGE && edge_ok) begin
					fwd_re = 1'b1;
					rev_re = 1'b1;
				end
			end
			ST_E_WR: begin
				fwd_we = 1'b1;
				rev_we = 1'b1;
			end
			ST_F_ROOT: begin
				stk_waddr = '0;
				stk_wdata = root_q[AW-1:0];
				stk_we    = (root_q != n_q) && !visited_q[root_q[AW-1:0]];
			end
			ST_F_RD: begin
				fwd_re = 1'b1;
			end
			ST_F_CHK: begin
				if (|fmask) begin
					stk_we = 1'b1;
				end else begin
					fo_we  = 1'b1;
					stk_re = (sp_q != CW'(1));
				end
			end
			ST_F_POP: begin
				fwd_re    = 1'b1;
				fwd_raddr = stk_rdata;
			end
			ST_R_K: begin
				fo_re = (k_q != '0);
			end
			ST_R_POPV: begin
				if (pend_q != '0) begin
					lbl_we = 1'b1;
					rev_re = 1'b1;
				end
			end
			ST_O_RD: begin
				lbl_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nv_cfg_q    <= NUM_VERTICES_RESET;
			fwd_vld_q   <= '0;
			rev_vld_q   <= '0;
			res_valid_q <= 1'b0;
			visited_q   <= '0;
			pend_q      <= '0;
			n_q         <= CW'(1);
			root_q      <= '0;
			sp_q        <= '0;
			fin_q       <= '0;
			k_q         <= '0;
			count_q     <= '0;
			ov_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				nv_cfg_q <= cfg_data;
			end
			// result register empties on transfer unless reloaded below
			if (res_valid_q && !res_stall && state_q != ST_O_LD) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						case (cmd_item.cmd)
							CMD_ADD_EDGE: begin
								if (edge_ok) begin
									state_q <= ST_E_WR;
								end
							end
							CMD_RUN: begin
								n_q       <= n_eff;
								visited_q <= '0;
								root_q    <= '0;
								fin_q     <= '0;
								count_q   <= '0;
								state_q   <= ST_F_ROOT;
							end
							CMD_CLEAR: begin
								fwd_vld_q <= '0;
								rev_vld_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_E_WR: begin
					fwd_vld_q[esrc_q] <= 1'b1;
					rev_vld_q[edst_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				// forward walk: roots in ascending order
				ST_F_ROOT: begin
					if (root_q == n_q) begin
						state_q <= ST_R_INIT;
					end else if (visited_q[root_q[AW-1:0]]) begin
						root_q <= root_q + CW'(1);
					end else begin
						visited_q[root_q[AW-1:0]] <= 1'b1;
						sp_q    <= CW'(1);
						state_q <= ST_F_RD;
					end
				end
				ST_F_RD: begin
					state_q <= ST_F_CHK;
				end
				ST_F_CHK: begin
					if (|fmask) begin
						visited_q[fpick] <= 1'b1;
						sp_q    <= sp_q + CW'(1);
						state_q <= ST_F_RD;
					end else begin
						fin_q <= fin_q + CW'(1);
						sp_q  <= sp_q - CW'(1);
						if (sp_q == CW'(1)) begin
							root_q  <= root_q + CW'(1);
							state_q <= ST_F_ROOT;
						end else begin
							state_q <= ST_F_POP;
						end
					end
				end
				ST_F_POP: begin
					state_q <= ST_F_CHK;
				end
				// reverse walk: roots in decreasing finish order
				ST_R_INIT: begin
					visited_q <= '0;
					pend_q    <= '0;
					count_q   <= '0;
					k_q       <= n_q;
					state_q   <= ST_R_K;
				end
				ST_R_K: begin
					if (k_q == '0) begin
						ov_q    <= '0;
						state_q <= ST_O_RD;
					end else begin
						state_q <= ST_R_ROOT;
					end
				end
				ST_R_ROOT: begin
					k_q <= km1;
					if (visited_q[fo_rdata]) begin
						state_q <= ST_R_K;
					end else begin
						count_q             <= count_q + CW'(1);
						visited_q[fo_rdata] <= 1'b1;
						pend_q[fo_rdata]    <= 1'b1;
						state_q             <= ST_R_POPV;
					end
				end
				ST_R_POPV: begin
					if (pend_q == '0) begin
						state_q <= ST_R_K;
					end else begin
						pend_q[ppick] <= 1'b0;
						state_q       <= ST_R_CHK;
					end
				end
				ST_R_CHK: begin
					visited_q <= visited_q | rmask;
					pend_q    <= pend_q | rmask;
					state_q   <= ST_R_POPV;
				end
				// result emission
				ST_O_RD: begin
					state_q <= ST_O_LD;
				end
				ST_O_LD: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							ov_q    <= ov_q + AW'(1);
							state_q <= ST_O_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			esrc_q <= cmd_item.src_vertex[AW-1:0];
			edst_q <= cmd_item.dst_vertex[AW-1:0];
		end
		if (fwd_re) begin
			fwd_rv_q <= fwd_vld_q[fwd_raddr];
		end
		if (rev_re) begin
			rev_rv_q <= rev_vld_q[rev_raddr];
		end
		if (state_q == ST_F_ROOT) begin
			top_q <= root_q[AW-1:0];
		end else if (state_q == ST_F_CHK && (|fmask)) begin
			top_q <= fpick;
		end else if (state_q == ST_F_POP) begin
			top_q <= stk_rdata;
		end
		if (state_q == ST_O_LD && out_free) begin
			res_q.vertex          <= 6'(ov_q);
			res_q.component       <= 7'(lbl_rdata);
			res_q.component_count <= 7'(count_q);
			res_q.last            <= out_last;
		end
	end

	scc_ram #(.WIDTH(W), .DEPTH(W)) u_fwd_rows (
		.clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
		.re(fwd_re), .raddr(fwd_raddr), .rdata(fwd_rdata)
	);

	scc_ram #(.WIDTH(W), .DEPTH(W)) u_rev_rows (
		.clk(clk), .we(rev_we), .waddr(rev_waddr), .wdata(rev_wdata),
		.re(rev_re), .raddr(rev_raddr), .rdata(rev_rdata)
	);

	scc_ram #(.WIDTH(AW), .DEPTH(W)) u_walk_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);

	scc_ram #(.WIDTH(AW), .DEPTH(W)) u_finish_order (
		.clk(clk), .we(fo_we), .waddr(fo_waddr), .wdata(fo_wdata),
		.re(fo_re), .raddr(fo_raddr), .rdata(fo_rdata)
	);

	scc_ram #(.WIDTH(CW), .DEPTH(W)) u_labels (
		.clk(clk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
		.re(lbl_re), .raddr(lbl_raddr), .rdata(lbl_rdata)
	);

	// stack depth never exceeds the vertex count
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= n_q) else $error("walk stack overflow");

	// finish slots never exceed the vertex count
	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q <= n_q) else $error("finish order overflow");

	// component count stays within the vertex count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= n_q) else $error("component count overflow");

	// the last result returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_O_LD && out_free && out_last) |=> (state_q == ST_IDLE && res_valid_q))
		else $error("run did not finish after last result");

endmodule

// File: verif/scc_checker.sv
// checker for the strongly connected components block: predicts labels and compares results
module scc_checker #(
	parameter int MAX_VERTICES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  scc_pkg::scc_in_t  cmd_item,
	input  logic              res_valid,
	input  logic              res_stall,
	input  scc_pkg::scc_out_t res_item,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [6:0]        cfg_data,
	output int                fail_count,
	output int                labels_pending
);
	import scc_pkg::*;

	logic [63:0] graph_rows [64];
	logic [6:0]  vertex_setting;
	scc_out_t    label_queue [$];

	// kosaraju over the local matrix, pushes one expected label per vertex
	task automatic predict_labels();
		int n, finished, sp, v, j, count, root;
		logic [63:0] seen;
		int order [64];
		int stack [64];
		int next_nb [64];
		int label [64];
		scc_out_t r;
		n = vertex_setting;
		if (n == 0) n = 1;
		if (n > MAX_VERTICES) n = MAX_VERTICES;
		seen = '0;
		finished = 0;
		// forward walk records finish order
		for (int s = 0; s < n; s++) begin
			if (!seen[s]) begin
				sp = 0;
				seen[s] = 1'b1;
				next_nb[s] = 0;
				stack[sp++] = s;
				while (sp > 0) begin
					v = stack[sp-1];
					j = next_nb[v];
					while (j < n && !(graph_rows[v][j] && !seen[j])) j++;
					if (j < n) begin
						next_nb[v] = j + 1;
						seen[j] = 1'b1;
						next_nb[j] = 0;
						stack[sp++] = j;
					end else begin
						sp--;
						order[finished++] = v;
					end
				end
			end
		end
		// reverse walk numbers components
		seen = '0;
		count = 0;
		for (int k = n; k > 0; k--) begin
			root = order[k-1];
			if (!seen[root]) begin
				count++;
				sp = 0;
				seen[root] = 1'b1;
				label[root] = count;
				stack[sp++] = root;
				while (sp > 0) begin
					v = stack[--sp];
					for (int i = 0; i < n; i++) begin
						if (graph_rows[i][v] && !seen[i]) begin
							seen[i] = 1'b1;
							label[i] = count;
							stack[sp++] = i;
						end
					end
				end
			end
		end
		for (int u = 0; u < n; u++) begin
			r.vertex = u[5:0];
			r.component = label[u][6:0];
			r.component_count = count[6:0];
			r.last = (u == n - 1);
			label_queue.push_back(r);
		end
	endtask

	// track transfers on every channel
	always @(posedge clk or negedge arst_n) begin
		scc_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) graph_rows[i] = '0;
			vertex_setting = NUM_VERTICES_RESET;
			label_queue.delete();
			fail_count = 0;
			labels_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				vertex_setting = cfg_data;
			if (cmd_valid && !cmd_stall) begin
				case (cmd_item.cmd)
					CMD_ADD_EDGE: begin
						if (cmd_item.src_vertex < MAX_VERTICES
								&& cmd_item.dst_vertex < MAX_VERTICES)
							graph_rows[cmd_item.src_vertex][cmd_item.dst_vertex] = 1'b1;
					end
					CMD_CLEAR: begin
						for (int i = 0; i < 64; i++) graph_rows[i] = '0;
					end
					CMD_RUN: predict_labels();
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (label_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer %p", res_item);
				end else begin
					want = label_queue.pop_front();
					if (res_item !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("label mismatch: expected %p, got %p", want, res_item);
					end
				end
			end
			labels_pending = label_queue.size();
		end
	end

endmodule

// File: verif/strongly_connected_components_top_tb.sv
// testbench top: stimulus, idling phases and verdict for the scc block
module strongly_connected_components_top_tb;
	import scc_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	scc_in_t    cmd_item = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	scc_out_t   res_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [6:0] cfg_data = '0;
	int         fail_count;
	int         labels_pending;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	always #1 clk = ~clk;

	strongly_connected_components_top #(.MAX_VERTICES(64)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	scc_checker #(.MAX_VERTICES(64)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .labels_pending(labels_pending)
	);

	// receiver stalls at random
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < recv_stall_pct);

	// one command transfer, with random idle cycles ahead of it; valid stays up after
	task automatic send_cmd(input logic [1:0] c, input int s, input int d);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= '{cmd: c, src_vertex: s[5:0], dst_vertex: d[5:0]};
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// drain all labels, let the block settle, then write the vertex count
	task automatic set_vertices(input int n);
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (labels_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n[6:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random graph phase: mostly edges among vertices in use, some noise
	task automatic graph_phase(input int n, input int items);
		int lim, pick;
		lim = (n < 1) ? 1 : (n > 64 ? 64 : n);
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send_cmd(CMD_ADD_EDGE, $urandom_range(lim - 1), $urandom_range(lim - 1));
			else if (pick < 83)
				send_cmd(CMD_ADD_EDGE, $urandom_range(63), $urandom_range(63));
			else if (pick < 95)
				send_cmd(CMD_RUN, $urandom_range(63), $urandom_range(63));
			else if (pick < 98)
				send_cmd(CMD_CLEAR, $urandom_range(63), $urandom_range(63));
			else
				send_cmd(2'd3, $urandom_range(63), $urandom_range(63));
		end
		send_cmd(CMD_RUN, 0, 0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: default count, cycle, self loop, extremes, unused command
		send_cmd(CMD_RUN, 0, 0);
		send_cmd(CMD_ADD_EDGE, 0, 63);
		send_cmd(CMD_ADD_EDGE, 63, 0);
		send_cmd(CMD_ADD_EDGE, 5, 5);
		send_cmd(CMD_ADD_EDGE, 1, 2);
		send_cmd(CMD_ADD_EDGE, 2, 1);
		send_cmd(2'd3, 63, 63);
		send_cmd(CMD_RUN, 63, 63);
		set_vertices(0);
		send_cmd(CMD_RUN, 0, 0);
		set_vertices(3);
		send_cmd(CMD_ADD_EDGE, 42, 21);
		send_cmd(CMD_RUN, 21, 42);
		send_cmd(CMD_CLEAR, 0, 0);
		send_cmd(CMD_RUN, 0, 0);
		set_vertices(127);
		send_cmd(CMD_RUN, 0, 0);
		set_vertices(65);
		send_cmd(CMD_ADD_EDGE, 63, 62);
		send_cmd(CMD_ADD_EDGE, 62, 63);
		send_cmd(CMD_RUN, 0, 0);
		send_cmd(CMD_CLEAR, 0, 0);
		// random phases over idling modes and vertex counts
		set_vertices(8);
		graph_phase(8, 20);
		send_idle_pct = 47;
		set_vertices(1);
		graph_phase(1, 10);
		recv_stall_pct = 47;
		send_idle_pct = 0;
		set_vertices(12);
		send_cmd(CMD_CLEAR, 0, 0);
		graph_phase(12, 20);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		set_vertices(64);
		graph_phase(64, 20);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_vertices($urandom_range(2, 16));
		send_cmd(CMD_CLEAR, 0, 0);
		graph_phase(16, 20);
		// wait out the results, then settle
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (labels_pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
src/scc_pkg.sv
src/scc_ram.sv
src/strongly_connected_components_top.sv
verif/scc_checker.sv
verif/strongly_connected_components_top_tb.sv
